// File: design/oktp_pkg.sv
package oktp_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [1:0] CMD_INSERT        = 2'd0;
	localparam logic [1:0] CMD_CLEAR         = 2'd1;
	localparam logic [1:0] CMD_LOOKUP_FIRST  = 2'd2;
	localparam logic [1:0] CMD_LOOKUP_SECOND = 2'd3;

	typedef struct packed {
		logic [30:0] first_key;
		logic [63:0] second_key;
	} pair_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [30:0] first_key;
		logic [63:0] second_key;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] found_second;
		logic [30:0] found_first;
		logic [6:0]  pairs_used;
	} rsp_t;

	// per-entry verdict of the compare unit
	typedef struct packed {
		logic drop;
		logic hit;
	} match_t;

endpackage

// File: design/oktp_pair_ram.sv
module oktp_pair_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 95
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/oktp_match.sv
module oktp_match (
	input  logic [1:0]      cmd,
	input  oktp_pkg::pair_t entry,
	input  logic [30:0]     first_key,
	input  logic [63:0]     second_key,
	input  logic            cleared,
	output oktp_pkg::match_t res
);
	import oktp_pkg::*;

	logic first_eq;
	logic second_eq;

	assign first_eq  = (entry.first_key == first_key);
	assign second_eq = (entry.second_key == second_key);

	always_comb begin
		res = '0;
		case (cmd)
			CMD_INSERT: begin
				res.drop = first_eq || second_eq;
			end
			CMD_CLEAR: begin
				// only the first pair with this key goes
				res.drop = first_eq && !cleared;
			end
			CMD_LOOKUP_FIRST: begin
				res.hit = first_eq;
			end
			CMD_LOOKUP_SECOND: begin
				res.hit = second_eq;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// File: design/one_to_one_key_pair_table_core.sv
// An operation scans all held pairs, none with an empty table; an insert with a zero key
// scans nothing.
// One operation at a time: the next request beat is taken only after the response is
// loaded, or later still while an earlier response beat waits for the consumer.
// Each held slot is read once per scan through the single read port of the pair memory.
// Reset clears the pair count and both handshakes; memory contents stay undefined
// and need no clearing pass, since only slots below the count are ever read.
module one_to_one_key_pair_table_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  oktp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output oktp_pkg::rsp_t rsp
);
	import oktp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t           state_q;

	// operation held for the whole scan
	logic [1:0]       cmd_q;
	logic [30:0]      fk_q;
	logic [63:0]      sk_q;
	logic             skip_q;      // insert with a zero key: change nothing

	logic [CNT_W-1:0] pair_cnt_q;
	logic [CNT_W-1:0] rd_q;        // next slot to read
	logic [CNT_W-1:0] wr_q;        // next slot to fill while compacting
	logic             cleared_q;
	logic             hit_q;
	pair_t            found_q;

	// read data stage
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// memory ports
	logic             ram_re;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	pair_t            ram_wdata;
	pair_t            ram_rdata;

	match_t           mres;
	logic             rsp_free;
	logic             modify;
	logic             keep_wr;
	logic             append;
	logic             has_room;
	logic [CNT_W-1:0] cnt_nxt;
	rsp_t             rsp_nxt;

	oktp_pair_ram #(
		.DEPTH (ENTRIES),
		.WIDTH ($bits(pair_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	oktp_match u_match (
		.cmd        (cmd_q),
		.entry      (ram_rdata),
		.first_key  (fk_q),
		.second_key (sk_q),
		.cleared    (cleared_q),
		.res        (mres)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// response register is free when empty or being drained this cycle
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign modify   = (cmd_q == CMD_INSERT) || (cmd_q == CMD_CLEAR);
	assign has_room = (wr_q != CNT_W'(ENTRIES));

	always_comb begin
		// read the slots in order, one per cycle, until the count is reached
		ram_re  = (state_q == ST_SCAN) && (rd_q != pair_cnt_q);

		// compact the survivors downward; skip the write while nothing has been dropped,
		// since the slot already holds the same pair
		keep_wr = (state_q == ST_SCAN) && rd_vld_s1 && modify && !mres.drop &&
		          (wr_q[IDX_W-1:0] != rd_idx_s1);

		// append lands after the scan, so it never meets a compaction write
		append  = (state_q == ST_FINISH) && rsp_free && (cmd_q == CMD_INSERT) &&
		          !skip_q && has_room;

		ram_we    = keep_wr || append;
		ram_waddr = wr_q[IDX_W-1:0];
		ram_wdata = append ? pair_t'{first_key: fk_q, second_key: sk_q} : ram_rdata;
	end

	// response and new count once the scan is over
	always_comb begin
		rsp_nxt = '0;
		cnt_nxt = pair_cnt_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (!skip_q) begin
					cnt_nxt    = has_room ? (wr_q + CNT_W'(1)) : wr_q;
					rsp_nxt.ok = has_room;
				end
			end
			CMD_CLEAR: begin
				cnt_nxt    = wr_q;
				rsp_nxt.ok = 1'b1;
			end
			CMD_LOOKUP_FIRST: begin
				rsp_nxt.ok           = hit_q;
				rsp_nxt.found_second = hit_q ? found_q.second_key : '0;
			end
			CMD_LOOKUP_SECOND: begin
				rsp_nxt.ok          = hit_q;
				rsp_nxt.found_first = hit_q ? found_q.first_key : '0;
			end
			default: begin
				rsp_nxt = '0;
			end
		endcase
		rsp_nxt.pairs_used = 7'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_INSERT;
			fk_q        <= '0;
			sk_q        <= '0;
			skip_q      <= 1'b0;
			pair_cnt_q  <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			cleared_q   <= 1'b0;
			hit_q       <= 1'b0;
			found_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// load the response beat when an operation ends, else drain it once taken
			if ((state_q == ST_FINISH) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			rd_vld_s1 <= ram_re;
			rd_idx_s1 <= rd_q[IDX_W-1:0];

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q     <= req.cmd;
						fk_q      <= req.first_key;
						sk_q      <= req.second_key;
						skip_q    <= (req.cmd == CMD_INSERT) &&
						             ((req.first_key == '0) || (req.second_key == '0));
						rd_q      <= '0;
						wr_q      <= '0;
						cleared_q <= 1'b0;
						hit_q     <= 1'b0;
						// a rejected insert touches no slot
						if ((req.cmd == CMD_INSERT) &&
						    ((req.first_key == '0) || (req.second_key == '0))) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (mres.drop) begin
							cleared_q <= 1'b1;
						end else if (modify) begin
							wr_q <= wr_q + CNT_W'(1);
						end
						// hold the first match only
						if (mres.hit && !hit_q) begin
							hit_q   <= 1'b1;
							found_q <= ram_rdata;
						end
					end
					// advance once every slot is read and the last read is consumed
					if (!ram_re && !rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						rsp_q      <= rsp_nxt;
						pair_cnt_q <= cnt_nxt;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// compaction never writes ahead of the read pointer
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (wr_q <= rd_q))
		else $error("compaction write pointer ran ahead of read pointer");

	// the count stays within the table
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_cnt_q <= CNT_W'(ENTRIES))
		else $error("pair count beyond table size");

	// read data only returns while scanning
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read data returned outside the scan");

	// lookups leave the count alone
	a_lookup_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && rsp_free &&
		 ((cmd_q == CMD_LOOKUP_FIRST) || (cmd_q == CMD_LOOKUP_SECOND)))
		|=> $stable(pair_cnt_q))
		else $error("lookup changed the pair count");

	// no write to the memory while the response waits for room
	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && !rsp_free) |-> !ram_we)
		else $error("memory written during a stalled finish");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import oktp_pkg::*;

	localparam int  CLK_HALF    = 5;
	localparam int  RESET_TICKS = 9;
	// One operation scans at most ENTRIES slots.
	localparam int  SETTLE_TICKS = ENTRIES + 16;
	// Slowest correct run: ~410 beats, each a full scan at most, plus random
	// gaps on both sides and one long hold-off. Taken several times over.
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  HOLD_CYCLES = 400;
	localparam int  POOL_MAX    = 48;

	localparam logic [30:0] FIRST_MAX  = 31'h7FFF_FFFF;
	localparam logic [63:0] SECOND_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SECOND_TOP = 64'h8000_0000_0000_0000;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	one_to_one_key_pair_table_core i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the pair table. Pairs stay packed in slots below
	// held_pairs, oldest first, exactly as the block keeps them.
	// ------------------------------------------------------------------
	logic [30:0] shadow_first  [ENTRIES];
	logic [63:0] shadow_second [ENTRIES];
	int          held_pairs     = 0;
	int          peak_pairs     = 0;
	int          refused_writes = 0;

	// Responses owed by the block, oldest at the front.
	rsp_t        rsp_owed_q [$];

	int          beats_in      = 0;
	int          rsps_checked  = 0;
	int          mismatches    = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	// The stimulus bumps hold_token; the receiver turns that into a stall.
	int          hold_token = 0;
	int          hold_seen  = 0;
	int          hold_left  = 0;

	logic [30:0] first_pool  [POOL_MAX];
	logic [63:0] second_pool [POOL_MAX];

	// Remove one pair and slide the younger ones down to close the gap.
	function automatic void drop_pair(int pos);
		for (int i = pos; i + 1 < held_pairs; i++) begin
			shadow_first[i]  = shadow_first[i + 1];
			shadow_second[i] = shadow_second[i + 1];
		end
		held_pairs--;
	endfunction

	// Apply one command to the shadow table and return the response it owes.
	function automatic rsp_t apply_table_op(req_t op);
		rsp_t r;
		r = '0;
		case (op.cmd)
			CMD_INSERT: begin
				if (op.first_key != '0 && op.second_key != '0) begin
					// Walk downward so a removal never skips a slot still to test.
					for (int i = held_pairs - 1; i >= 0; i--) begin
						if (shadow_first[i] == op.first_key || shadow_second[i] == op.second_key)
							drop_pair(i);
					end
					if (held_pairs < ENTRIES) begin
						shadow_first[held_pairs]  = op.first_key;
						shadow_second[held_pairs] = op.second_key;
						held_pairs++;
						r.ok = 1'b1;
					end else begin
						refused_writes++;
					end
				end else begin
					refused_writes++;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < held_pairs; i++) begin
					if (shadow_first[i] == op.first_key) begin
						drop_pair(i);
						break;
					end
				end
				r.ok = 1'b1;
			end
			CMD_LOOKUP_FIRST: begin
				for (int i = 0; i < held_pairs; i++) begin
					if (shadow_first[i] == op.first_key) begin
						r.found_second = shadow_second[i];
						r.ok = 1'b1;
						break;
					end
				end
			end
			default: begin
				for (int i = 0; i < held_pairs; i++) begin
					if (shadow_second[i] == op.second_key) begin
						r.found_first = shadow_first[i];
						r.ok = 1'b1;
						break;
					end
				end
			end
		endcase
		r.pairs_used = 7'(held_pairs);
		if (held_pairs > peak_pairs)
			peak_pairs = held_pairs;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side: optionally idle, then hold the beat until it is taken.
	// Handshake signals are sampled right at the edge, before the block's
	// own updates land, so the check sees what the block saw.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [1:0] op, input logic [30:0] fk,
				 input logic [63:0] sk);
		req_t item;
		item = '{cmd: op, first_key: fk, second_key: sk};
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		// Taken at this edge: book the response it owes.
		rsp_owed_q.push_back(apply_table_op(item));
		beats_in++;
	endtask

	// ------------------------------------------------------------------
	// Response side: check every beat against the oldest owed response,
	// then pick the next ready value (long hold-off first, else random).
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] response beat with nothing owed: ok=%0b sec=%h first=%h used=%0d",
						 $realtime, rsp.ok, rsp.found_second, rsp.found_first,
						 rsp.pairs_used);
			end else begin
				want = rsp_owed_q.pop_front();
				rsps_checked++;
				if (rsp.ok !== want.ok || rsp.found_second !== want.found_second ||
				    rsp.found_first !== want.found_first ||
				    rsp.pairs_used !== want.pairs_used) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] mismatch on response %0d", $realtime, rsps_checked);
						$display("  want ok=%0b sec=%h first=%h used=%0d",
							 want.ok, want.found_second, want.found_first, want.pairs_used);
						$display("  got  ok=%0b sec=%h first=%h used=%0d",
							 rsp.ok, rsp.found_second, rsp.found_first, rsp.pairs_used);
					end
				end
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d responses still owed",
				 cycle_count, rsp_owed_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Key sources for the random mix: mostly a small pool so that keys
	// collide, plus fresh random keys and the odd zero key.
	// ------------------------------------------------------------------
	task automatic refresh_pools(int pool_n);
		for (int i = 0; i < pool_n; i++) begin
			first_pool[i]  = 31'($urandom);
			second_pool[i] = {$urandom, $urandom};
			if (first_pool[i] == '0)
				first_pool[i] = 31'd1;
			if (second_pool[i] == '0)
				second_pool[i] = 64'd1;
		end
		first_pool[0]  = FIRST_MAX;
		first_pool[1]  = 31'd1;
		second_pool[0] = SECOND_MAX;
		second_pool[1] = 64'd1;
		second_pool[2] = SECOND_TOP;
	endtask

	function automatic logic [30:0] pick_first_key(int pool_n);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 80)
			return first_pool[$urandom_range(pool_n - 1)];
		return 31'($urandom);
	endfunction

	function automatic logic [63:0] pick_second_key(int pool_n);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 80)
			return second_pool[$urandom_range(pool_n - 1)];
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Zero keys, extreme keys, replacement on either key, double drop,
	// clear with and without a match, lookups of zero.
	task automatic test_directed_corners();
		send_item(CMD_INSERT, '0, 64'd5);
		send_item(CMD_INSERT, 31'd5, '0);
		send_item(CMD_INSERT, '0, '0);
		send_item(CMD_LOOKUP_FIRST, '0, '0);
		send_item(CMD_LOOKUP_SECOND, '0, '0);
		send_item(CMD_CLEAR, 31'd77, '0);
		send_item(CMD_INSERT, FIRST_MAX, SECOND_MAX);
		send_item(CMD_INSERT, 31'd1, 64'd1);
		send_item(CMD_LOOKUP_FIRST, FIRST_MAX, 64'd1);
		send_item(CMD_LOOKUP_SECOND, FIRST_MAX, 64'd1);
		send_item(CMD_LOOKUP_FIRST, '0, SECOND_MAX);
		send_item(CMD_LOOKUP_SECOND, 31'd1, '0);
		// same first key, new second key: old pair goes, new one lands on top
		send_item(CMD_INSERT, 31'd1, SECOND_TOP);
		// second key already held by another first key
		send_item(CMD_INSERT, 31'h4000_0000, SECOND_MAX);
		// exact duplicate: dropped and appended again
		send_item(CMD_INSERT, 31'd1, SECOND_TOP);
		send_item(CMD_LOOKUP_SECOND, '0, SECOND_MAX);
		// each key sits in a different pair: both pairs go
		send_item(CMD_INSERT, 31'h4000_0000, SECOND_TOP);
		send_item(CMD_LOOKUP_FIRST, 31'd1, '0);
		send_item(CMD_CLEAR, 31'h1234_5678, SECOND_TOP);
		send_item(CMD_CLEAR, 31'h4000_0000, {$urandom, $urandom});
		send_item(CMD_CLEAR, 31'h4000_0000, '0);
	endtask

	// Fill to capacity with distinct pairs, hit the full-table cases,
	// then drain in random order with lookups mixed in.
	task automatic test_full_table();
		logic [30:0] fk_list [$];
		logic [63:0] sk_list [$];
		int          pick;
		for (int i = 0; i < ENTRIES; i++) begin
			fk_list.push_back({24'($urandom), 7'(i + 1)});
			sk_list.push_back({57'({$urandom, $urandom}), 7'(i + 1)});
			send_item(CMD_INSERT, fk_list[i], sk_list[i]);
		end
		// full, no key shared: refused
		send_item(CMD_INSERT, {24'($urandom), 7'd100}, {57'({$urandom, $urandom}), 7'd100});
		// full, one key shared: replaced, still full
		send_item(CMD_INSERT, fk_list[10], {57'({$urandom, $urandom}), 7'd101});
		// full, keys in two different pairs: two drops, one append
		send_item(CMD_INSERT, fk_list[3], sk_list[20]);
		send_item(CMD_INSERT, {24'($urandom), 7'd102}, {57'({$urandom, $urandom}), 7'd102});
		send_item(CMD_INSERT, '0, sk_list[5]);
		send_item(CMD_LOOKUP_FIRST, fk_list[ENTRIES - 1], '0);
		send_item(CMD_LOOKUP_SECOND, '0, sk_list[0]);
		send_item(CMD_LOOKUP_SECOND, '0, sk_list[20]);
		while (fk_list.size() > 0) begin
			pick = $urandom_range(fk_list.size() - 1);
			send_item(CMD_CLEAR, fk_list[pick], {$urandom, $urandom});
			if ($urandom_range(1) == 0)
				send_item(CMD_LOOKUP_SECOND, 31'($urandom),
					  sk_list[$urandom_range(sk_list.size() - 1)]);
			fk_list.delete(pick);
			sk_list.delete(pick);
		end
	endtask

	// Random commands over colliding keys; a smaller pool makes keys collide more often.
	task automatic test_random_mix(int count, int pool_n);
		int unsigned roll;
		logic [1:0]  op;
		refresh_pools(pool_n);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 40)
				op = CMD_INSERT;
			else if (roll < 55)
				op = CMD_CLEAR;
			else if (roll < 78)
				op = CMD_LOOKUP_FIRST;
			else
				op = CMD_LOOKUP_SECOND;
			send_item(op, pick_first_key(pool_n), pick_second_key(pool_n));
		end
	endtask

	// Hold the response side off for a long stretch while requests keep
	// coming, so the block sits on a finished response and stops taking beats.
	task automatic test_backpressure();
		hold_token <= hold_token + 1;
		test_random_mix(16, 12);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 51;
		test_directed_corners();
		test_full_table();

		send_idle_pct = 51;
		recv_idle_pct = 10;
		test_random_mix(100, 12);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(100, 40);
		test_backpressure();

		req_valid <= 1'b0;
		while (rsp_owed_q.size() != 0)
			@(posedge clk);
		// Let any stray response show up before the verdict.
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("Covered %0d request beats and %0d checked responses over all four commands",
			 beats_in, rsps_checked);
		$display("Table peaked at %0d of %0d pairs, %0d inserts refused, %0d-cycle hold-off",
			 peak_pairs, ENTRIES, refused_writes, HOLD_CYCLES);
		if (mismatches == 0 && rsp_owed_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d bad responses", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
